/* hw/rtl/wrrls_pkg.sv */
`default_nettype none
package wrrls_pkg;

  // configuration port geometry: one 64-bit register at byte address 0
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned LANE_W     = 8;
  localparam int unsigned LINK_IDX_W = 3;

  // register index decoded from paddr[3]
  localparam logic REG_LINK_WEIGHTS = 1'b0;

  // reset value of the weight register: every link weight one
  localparam logic [CFG_DATA_W-1:0] WEIGHTS_RST = 64'h0101_0101_0101_0101;

  // search state handed from one cell to the next
  typedef struct packed {
    logic hi_free;     // no eligible link found yet at or after the start index
    logic lo_free;     // no eligible link found yet from link zero
    logic first_free;  // no active link found yet from link zero
  } wrrls_chain_t;

  // decision broadcast back to every cell
  typedef struct packed {
    logic advance;     // word taken and at least one link active
    logic any_elig;    // some active link still has credit
    logic found_hi;    // the winner lies at or after the start index
  } wrrls_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/weighted_round_robin_link_select.sv */
// the result word is registered and appears in the cycle after its request word is taken
// throughput: one request word per cycle unless a held result is not read; the search runs
//   combinationally through one row of link cells and the result register frees as it is read
// reset: credits and start index clear to zero, every link weight resets to one
`default_nettype none
module weighted_round_robin_link_select
  import wrrls_pkg::*;
#(
  parameter int unsigned NUM_LINKS   = 8,
  parameter int unsigned WEIGHT_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_active_mask,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_granted,
  output logic [LINK_IDX_W-1:0]      out_link_index,
  // configuration port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int unsigned IDX_W = $clog2(NUM_LINKS);

  logic [CFG_DATA_W-1:0] link_weights_r;
  logic [IDX_W-1:0]      start_r;
  logic [IDX_W-1:0]      start_nxt;
  logic                  out_valid_r;
  logic                  out_granted_r;
  logic [LINK_IDX_W-1:0] out_link_r;

  wrrls_chain_t          chain [NUM_LINKS+1];
  wrrls_ctl_t            ctl;
  logic [NUM_LINKS-1:0]  pick;
  logic [NUM_LINKS-1:0]  first;
  logic [IDX_W-1:0]      pick_idx;
  logic [IDX_W-1:0]      first_idx;
  logic [IDX_W-1:0]      grant_idx;
  logic                  any_active;
  logic                  in_take;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[3] == REG_LINK_WEIGHTS) ? link_weights_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_weights_r <= WEIGHTS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[3] == REG_LINK_WEIGHTS)) begin
      link_weights_r <= cfg_pwdata;
    end
  end

  // handshake: the result register parts the two sides
  assign in_ready = !out_valid_r || out_ready;
  assign in_take  = in_valid && in_ready;

  // row of link cells
  assign chain[0] = '{hi_free: 1'b1, lo_free: 1'b1, first_free: 1'b1};

  for (genvar i = 0; i < NUM_LINKS; i++) begin : g_cell
    wrrls_cell #(
      .WEIGHT_BITS(WEIGHT_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .active     (in_active_mask[i]),
      .at_or_after(IDX_W'(i) >= start_r),
      .weight     (link_weights_r[LANE_W*i +: WEIGHT_BITS]),
      .ctl        (ctl),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .pick       (pick[i]),
      .first      (first[i])
    );
  end

  // decision from the end of the row
  assign any_active   = !chain[NUM_LINKS].first_free;
  assign ctl.advance  = in_take && any_active;
  assign ctl.any_elig = !chain[NUM_LINKS].lo_free;
  assign ctl.found_hi = !chain[NUM_LINKS].hi_free;

  // encode the one-hot winners
  always_comb begin
    pick_idx  = '0;
    first_idx = '0;
    for (int i = 0; i < NUM_LINKS; i++) begin
      if (pick[i]) begin
        pick_idx = pick_idx | IDX_W'(i);
      end
      if (first[i]) begin
        first_idx = first_idx | IDX_W'(i);
      end
    end
  end

  assign grant_idx = ctl.any_elig ? pick_idx : first_idx;

  // start index moves past a credit grant, or onto the reloaded winner
  always_comb begin
    start_nxt = start_r;
    if (ctl.advance) begin
      if (ctl.any_elig) begin
        if (pick_idx == IDX_W'(NUM_LINKS - 1)) begin
          start_nxt = '0;
        end else begin
          start_nxt = pick_idx + IDX_W'(1);
        end
      end else begin
        start_nxt = first_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
    end else begin
      start_r <= start_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_granted_r <= any_active;
      out_link_r    <= any_active ? LINK_IDX_W'(grant_idx) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_granted    = out_granted_r;
  assign out_link_index = out_link_r;

endmodule
`default_nettype wire

/* hw/rtl/wrrls_cell.sv */
`default_nettype none
module wrrls_cell
  import wrrls_pkg::*;
#(
  parameter int unsigned WEIGHT_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   active,
  input  wire logic                   at_or_after,
  input  wire logic [WEIGHT_BITS-1:0] weight,
  input  wire wrrls_ctl_t             ctl,
  input  wire wrrls_chain_t           chain_in,
  output wrrls_chain_t                chain_out,
  output logic                        pick,
  output logic                        first
);

  logic [WEIGHT_BITS-1:0] credit_r;
  logic [WEIGHT_BITS-1:0] credit_nxt;
  logic                   elig;
  logic                   elig_hi;

  // eligibility of this link
  assign elig    = active && (credit_r != '0);
  assign elig_hi = elig && at_or_after;

  // pass the search on to the next link
  always_comb begin
    chain_out.hi_free    = chain_in.hi_free && !elig_hi;
    chain_out.lo_free    = chain_in.lo_free && !elig;
    chain_out.first_free = chain_in.first_free && !active;
  end

  // this link wins the round
  assign pick  = ctl.found_hi ? (elig_hi && chain_in.hi_free) : (elig && chain_in.lo_free);
  assign first = active && chain_in.first_free;

  // credit update: spend one on a grant, or reload from the weight
  always_comb begin
    credit_nxt = credit_r;
    if (ctl.advance) begin
      if (ctl.any_elig) begin
        if (pick) begin
          credit_nxt = credit_r - WEIGHT_BITS'(1);
        end
      end else begin
        if (first && (weight != '0)) begin
          credit_nxt = weight - WEIGHT_BITS'(1);
        end else begin
          credit_nxt = weight;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

endmodule
`default_nettype wire
